>>> src/stl_pkg.sv
// Shared constants, types and sine table generator for the stereo tremolo LFO.
package stl_pkg;

   localparam int PHASE_BITS_DEF   = 24;
   localparam int SINE_ENTRIES_DEF = 256;
   localparam int SAMPLE_BITS_DEF  = 24;
   localparam int CHANNELS         = 2;
   localparam int CHAN_BITS        = 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int WAVE_BITS      = 18;
   localparam int ROM_BITS       = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP,
      CSR_DEPTH,
      CSR_WAVE_SHAPE,
      CSR_STEREO_OFFSET
   } csr_index_type;

   typedef enum logic [1:0] {
      SHAPE_SINE,
      SHAPE_SQUARE,
      SHAPE_TRIANGLE,
      SHAPE_RAMP
   } wave_shape_type;

   localparam logic [15:0] PHASE_STEP_RST    = 16'd437;
   localparam logic [15:0] DEPTH_RST         = 16'd16384;
   localparam logic [15:0] STEREO_OFFSET_RST = 16'd0;
   localparam logic [15:0] DEPTH_FULL        = 16'd32768;
   localparam logic [31:0] GAIN_ONE          = 32'h8000_0000;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint Q30_ONE     = 64'sd1073741824;

   typedef struct packed {
      logic                 rd_en;
      logic [CHAN_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [CHAN_BITS-1:0] wr_addr;
   } phase_mem_ctl_type;

   // Taylor series of sin(x), x in Q30, result rounded to Q15 and capped
   function automatic logic [ROM_BITS-1:0] sine_from_x(input longint x);
      longint term;
      longint sum;
      longint r;
      term = x;
      sum  = x;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 6);
      sum  = sum + term;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 20);
      sum  = sum + term;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 42);
      sum  = sum + term;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 72);
      sum  = sum + term;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 110);
      sum  = sum + term;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 156);
      sum  = sum + term;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 210);
      sum  = sum + term;
      term = (term * x) / Q30_ONE; term = (term * x) / Q30_ONE; term = -(term / 272);
      sum  = sum + term;
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 16384) / 32768;
      if (r > 32767) begin
         r = 32767;
      end
      return r[ROM_BITS-1:0];
   endfunction

endpackage

>>> src/stl_phase_mem.sv
// Per-channel LFO phase memory with registered read, valid bits and write forwarding.
module stl_phase_mem #(
   parameter int PHASE_BITS = stl_pkg::PHASE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stl_pkg::phase_mem_ctl_type ctl,
   input  logic [PHASE_BITS-1:0]      wr_data,
   output logic [PHASE_BITS-1:0]      rd_data
);
   import stl_pkg::*;

   logic [PHASE_BITS-1:0] phase_mem [CHANNELS];
   logic [CHANNELS-1:0]   valid_ff;
   logic [PHASE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         phase_mem[ctl.wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         if (ctl.wr_en && ctl.wr_addr == ctl.rd_addr) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[ctl.rd_addr]) begin
            rd_data_ff <= phase_mem[ctl.rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/stl_wave.sv
// LFO waveform generator: quarter-wave sine ROM plus square, triangle and saw.
module stl_wave #(
   parameter int PHASE_BITS   = stl_pkg::PHASE_BITS_DEF,
   parameter int SINE_ENTRIES = stl_pkg::SINE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic [PHASE_BITS-1:0]               phase,
   input  stl_pkg::wave_shape_type             shape,
   output logic signed [stl_pkg::WAVE_BITS-1:0] wave
);
   import stl_pkg::*;

   localparam int IDX_BITS  = $clog2(SINE_ENTRIES);
   localparam int SCL_BITS  = PHASE_BITS - 2 + IDX_BITS;

   logic [ROM_BITS-1:0] rom_table [SINE_ENTRIES];

   for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
      localparam longint ARG = (HALF_PI_Q30 * g) / SINE_ENTRIES;
      localparam logic [ROM_BITS-1:0] VAL = sine_from_x(ARG);
      assign rom_table[g] = VAL;
   end

   logic [SCL_BITS-1:0]   frac_scaled;
   logic [IDX_BITS-1:0]   idx;
   logic [IDX_BITS-1:0]   rom_addr;
   logic                  peak;

   logic [PHASE_BITS-1:0] phase_ff;
   logic                  peak_ff;
   logic [ROM_BITS-1:0]   rom_data_ff;

   logic [PHASE_BITS+16:0] tri_ext;
   logic [PHASE_BITS+15:0] saw_ext;
   logic [16:0]            tri_v;
   logic [15:0]            saw_v;
   logic                   upper_half;
   logic signed [WAVE_BITS-1:0] sine_mag;

   always_comb begin
      frac_scaled = SCL_BITS'(phase[PHASE_BITS-3:0]) * SCL_BITS'(SINE_ENTRIES);
      idx         = frac_scaled[SCL_BITS-1:PHASE_BITS-2];
      peak        = phase[PHASE_BITS-2] && (idx == '0);
      if (phase[PHASE_BITS-2] && !peak) begin
         rom_addr = IDX_BITS'((IDX_BITS+1)'(SINE_ENTRIES) - (IDX_BITS+1)'(idx));
      end else if (peak) begin
         rom_addr = '0;
      end else begin
         rom_addr = idx;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         phase_ff    <= phase;
         peak_ff     <= peak;
         rom_data_ff <= rom_table[rom_addr];
      end
   end

   always_comb begin
      tri_ext    = {phase_ff, 17'd0};
      saw_ext    = {phase_ff, 16'd0};
      tri_v      = tri_ext[PHASE_BITS+16:PHASE_BITS];
      saw_v      = saw_ext[PHASE_BITS+15:PHASE_BITS];
      upper_half = phase_ff[PHASE_BITS-1];
      sine_mag   = peak_ff ? WAVE_BITS'(32768) : $signed({2'b00, rom_data_ff});
      case (shape)
         SHAPE_SQUARE: begin
            wave = (phase_ff != '0 && !upper_half) ? WAVE_BITS'(32768) : -WAVE_BITS'(32768);
         end
         SHAPE_TRIANGLE: begin
            wave = upper_half ? WAVE_BITS'(98304) - $signed({1'b0, tri_v})
                              : $signed({1'b0, tri_v}) - WAVE_BITS'(32768);
         end
         SHAPE_RAMP: begin
            wave = upper_half ? $signed({2'b00, saw_v}) - WAVE_BITS'(65536)
                              : $signed({2'b00, saw_v});
         end
         default: begin
            wave = phase_ff[PHASE_BITS-1] ? -sine_mag : sine_mag;
         end
      endcase
   end

endmodule

>>> src/stereo_tremolo_lfo.sv
// Stereo tremolo: scales each audio sample by an LFO-driven gain, one LFO phase per channel.
//
// Each sample passes through the transfer, a read of the channel's phase from
// the phase memory (written back advanced in the next cycle), the oscillator and
// gain computation, and the sample multiply into the output register, which waits
// while that register holds an untaken result. One sample is in flight at a time,
// so this whole sequence sets the rate. The output register lets a new sample be
// taken while the last result still waits. Configuration writes are taken every cycle.
module stereo_tremolo_lfo #(
   parameter int PHASE_BITS   = stl_pkg::PHASE_BITS_DEF,
   parameter int SINE_ENTRIES = stl_pkg::SINE_ENTRIES_DEF,
   parameter int SAMPLE_BITS  = stl_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   input  logic [stl_pkg::CHAN_BITS-1:0]         req_chan,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [stl_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [stl_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import stl_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_GAIN,
      ST_MUL
   } state_type;

   // configuration
   logic [15:0]    phase_step_ff;
   logic [15:0]    depth_ff;
   wave_shape_type wave_shape_ff;
   logic [15:0]    stereo_offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= PHASE_STEP_RST;
         depth_ff         <= DEPTH_RST;
         wave_shape_ff    <= SHAPE_SINE;
         stereo_offset_ff <= STEREO_OFFSET_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PHASE_STEP:    phase_step_ff    <= csr_data;
            CSR_DEPTH:         depth_ff         <= csr_data;
            CSR_WAVE_SHAPE:    wave_shape_ff    <= wave_shape_type'(csr_data[1:0]);
            CSR_STEREO_OFFSET: stereo_offset_ff <= csr_data;
            default:           ;
         endcase
      end
   end

   // datapath and control
   state_type                   state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [CHAN_BITS-1:0]        chan_ff, chan_in;
   logic [31:0]                 gain_ff, gain_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   phase_mem_ctl_type           mem_ctl;
   logic [PHASE_BITS-1:0]       phase_rd;
   logic [PHASE_BITS-1:0]       phase_wr;
   logic [PHASE_BITS-1:0]       lfo_phase;
   logic [PHASE_BITS-1:0]       step;
   logic                        wave_load;
   logic signed [WAVE_BITS-1:0] wave;

   logic [15:0]                 depth_sat;
   logic [16:0]                 wave_u;
   logic [32:0]                 depth_prod;
   logic [SAMPLE_BITS-1:0]      mag;
   logic [PROD_BITS-1:0]        prod;
   logic [SAMPLE_BITS-1:0]      scaled;
   logic                        out_free;

   stl_phase_mem #(
      .PHASE_BITS(PHASE_BITS)
   ) u_phase_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_data (phase_wr),
      .rd_data (phase_rd)
   );

   stl_wave #(
      .PHASE_BITS  (PHASE_BITS),
      .SINE_ENTRIES(SINE_ENTRIES)
   ) u_wave (
      .clock(clock),
      .load (wave_load),
      .phase(lfo_phase),
      .shape(wave_shape_ff),
      .wave (wave)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      step       = (phase_step_ff == '0) ? PHASE_BITS'(1) : PHASE_BITS'(phase_step_ff);
      lfo_phase  = chan_ff[0]
                   ? phase_rd + (PHASE_BITS'(stereo_offset_ff) << (PHASE_BITS - 16))
                   : phase_rd;
      phase_wr   = phase_rd + step;

      depth_sat  = (depth_ff > DEPTH_FULL) ? DEPTH_FULL : depth_ff;
      wave_u     = 17'(wave + WAVE_BITS'(32768));
      depth_prod = 33'(depth_sat) * 33'(wave_u);

      mag        = sample_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_ff) : sample_ff;
      prod       = PROD_BITS'(mag) * PROD_BITS'(gain_ff);
      scaled     = prod[SAMPLE_BITS+30:31];
      out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      chan_in       = chan_ff;
      gain_in       = gain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      mem_ctl       = '0;
      wave_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            mem_ctl.rd_addr = req_chan;
            if (req_valid) begin
               mem_ctl.rd_en = 1'b1;
               sample_in     = req_sample_in;
               chan_in       = req_chan;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = chan_ff;
            wave_load       = 1'b1;
            state_in        = ST_GAIN;
         end
         ST_GAIN: begin
            gain_in  = 32'(33'(GAIN_ONE) - depth_prod);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff[SAMPLE_BITS-1] ? $signed(-scaled) : $signed(scaled);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      chan_ff       <= chan_in;
      gain_ff       <= gain_in;
      rsp_sample_ff <= rsp_sample_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule
